>>> rtl/rhd_pkg.sv
// Shared types and constants of the RTP H.264 depacketiser.
package rhd_pkg;

  localparam int PACKET_DEPTH_DEF = 2048;
  localparam int UNIT_DEPTH_DEF   = 65536;

  localparam int POS_W = 20;   // packet positions, room for a full extension length
  localparam int LEN_W = 17;   // unit and packet lengths

  localparam int RTP_HDR_LEN  = 12;
  localparam int RTP_VERSION  = 2;
  localparam int SC_LEN       = 4;

  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_STAPA = 5'd24;
  localparam logic [4:0] NAL_FUA   = 5'd28;
  localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;

  localparam logic [2:0] PS_OK       = 3'd0;
  localparam logic [2:0] PS_MALFORM  = 3'd1;
  localparam logic [2:0] PS_EMPTY    = 3'd2;
  localparam logic [2:0] PS_SKIP     = 3'd3;
  localparam logic [2:0] PS_OVERFLOW = 3'd4;
  localparam logic [2:0] PS_TOO_LONG = 3'd5;

  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RDATA,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_X1, ST_X2, ST_SEQ, ST_T0, ST_T1, ST_DISP,
    ST_SN_LOOP, ST_SN_H, ST_SN_L, ST_SN_N,
    ST_SA_LOOP, ST_SA_H, ST_SA_L,
    ST_SC, ST_HDR, ST_CHK, ST_CP_RD, ST_CP_WR, ST_POST, ST_MARK, ST_FAIL
  } state_t;

  typedef enum logic [1:0] {
    JOB_NAL, JOB_STAP, JOB_FU_S, JOB_FU_C
  } job_t;

endpackage

>>> rtl/rhd_unit_store.sv
// Access-unit byte store with registered read and zeroing of reads past the unit.
module rhd_unit_store
  import rhd_pkg::*;
#(
  parameter int UNIT_DEPTH = UNIT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(UNIT_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic [$clog2(UNIT_DEPTH)-1:0] rd_addr,
  input  logic                          rd_hit,
  output logic [7:0]                    rd_data
);

  logic [7:0] mem [UNIT_DEPTH];
  logic [7:0] q_r;
  logic       hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r   <= mem[rd_addr];
    hit_r <= rd_hit;
  end

  // beyond the finished unit reads as zero
  assign rd_data = hit_r ? q_r : 8'd0;

endmodule

>>> rtl/rtp_h264_depacketizer_unit.sv
// Top level of the RTP H.264 depacketiser: packet store, parse sequencer, unit store.
//
// Packets arrive one byte per transaction (operation 0) and are written to the
// packet store. At the packet's last byte the sequencer walks the stored
// packet through the single read port of the packet store: the RTP header,
// its header extension if present, dispatch, then a start code and every
// payload byte copied to the access-unit store (read, then write), with a room
// check and close for each copied chunk and an STAP-A entry header read before
// each entry; while discarding, an STAP-A packet is first scanned for an IDR
// entry by entry. A read transaction is operation 1. One transaction is in
// flight at a time; a new one is taken once the result register is free or
// being emptied. The au_limit write is taken at any time but must only be
// issued while the block is idle. Status codes: accepted, malformed, empty
// payload, skipped while discarding, overflow or inconsistency, too long.
module rtp_h264_depacketizer_unit
  import rhd_pkg::*;
#(
  parameter int PACKET_DEPTH = PACKET_DEPTH_DEF,
  parameter int UNIT_DEPTH   = UNIT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input transactions
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic [15:0]       in_read_address,
  // result transactions
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_result_kind,
  output logic [2:0]        out_packet_status,
  output logic              out_unit_ready,
  output logic [LEN_W-1:0]  out_unit_length,
  output logic              out_unit_has_idr,
  output logic              out_discarding_now,
  output logic [7:0]        out_read_data,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_au_limit
);

  localparam int PA  = $clog2(PACKET_DEPTH);
  localparam int PCW = PA + 1;
  localparam int UA  = $clog2(UNIT_DEPTH);
  localparam logic [PCW-1:0] PKT_FULL = PCW'(PACKET_DEPTH);
  localparam logic [20:0]    UD_W     = 21'(UNIT_DEPTH);

  // ---------------------------------------------------------------- state
  state_t            st_r, st_nxt;
  job_t              job_r, job_nxt;
  logic [PCW-1:0]    cnt_r, cnt_nxt;
  logic              ovl_r, ovl_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  hl_r, hl_nxt;
  logic [POS_W-1:0]  ptr_r, ptr_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;
  logic              idr_r, idr_nxt;
  logic              frag_r, frag_nxt;
  logic              drop_r, drop_nxt;
  logic              seqk_r, seqk_nxt;
  logic [15:0]       prev_seq_r, prev_seq_nxt;
  logic [15:0]       seq_r, seq_nxt;
  logic              marker_r, marker_nxt;
  logic              ext_r, ext_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [7:0]        pay0_r, pay0_nxt;
  logic [7:0]        pay1_r, pay1_nxt;
  logic [7:0]        nal0_r, nal0_nxt;
  logic              first_r, first_nxt;
  logic [1:0]        sc_idx_r, sc_idx_nxt;
  logic [LEN_W-1:0]  au_limit_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [2:0]        out_status_r;
  logic              out_uready_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_idr_r;
  logic              out_disc_r;
  logic [7:0]        out_data_r;

  // finish strobes from the sequencer
  logic              fin, fin_rd;
  logic [2:0]        fin_status;
  logic              fin_ready;
  logic [LEN_W-1:0]  fin_len;
  logic              fin_idr;

  // packet store
  logic [7:0]        pkt_mem [PACKET_DEPTH];
  logic [7:0]        pkt_q;
  logic              pkt_we;
  logic [PA-1:0]     pkt_waddr;
  logic [PA-1:0]     pkt_raddr;

  // unit store
  logic              unit_we;
  logic [7:0]        unit_wdata;
  logic [UA+16:0]    fill_ext;
  logic [UA+15:0]    raddr_ext;
  logic [7:0]        unit_rdata;
  logic              rd_hit;

  logic [LEN_W-1:0]  cap;
  logic [POS_W-1:0]  len20;
  logic [POS_W-1:0]  hl_p1, hl_p2, hl_p3, ptr_p1, ptr_p2, nhl, sz_end;
  logic [15:0]       sz;
  logic [4:0]        ntype;
  logic              pl2;
  logic              in_acc;

  function automatic logic fits(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] n,
                                input logic [LEN_W-1:0] c);
    fits = ({1'b0, f} + {1'b0, n}) <= {1'b0, c};
  endfunction

  assign cap = ({4'd0, au_limit_r} < UD_W) ? au_limit_r : UD_W[LEN_W-1:0];

  assign len20  = {{(POS_W-LEN_W){1'b0}}, len_r};
  assign hl_p1  = hl_r + POS_W'(1);
  assign hl_p2  = hl_r + POS_W'(2);
  assign hl_p3  = hl_r + POS_W'(3);
  assign ptr_p1 = ptr_r + POS_W'(1);
  assign ptr_p2 = ptr_r + POS_W'(2);
  assign nhl    = hl_r + POS_W'(SC_LEN) + {2'b00, hi_r, pkt_q, 2'b00};
  assign sz     = {hi_r, pkt_q};
  assign sz_end = ptr_p2 + {4'd0, sz};
  assign ntype  = pay0_r[4:0];
  assign pl2    = hl_p2 <= len20;

  assign fill_ext  = {{UA{1'b0}}, fill_r};
  assign raddr_ext = {{UA{1'b0}}, in_read_address};
  assign rd_hit    = {1'b0, in_read_address} < last_len_r;

  assign in_ready  = (st_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    st_nxt       = st_r;
    job_nxt      = job_r;
    cnt_nxt      = cnt_r;
    ovl_nxt      = ovl_r;
    len_nxt      = len_r;
    hl_nxt       = hl_r;
    ptr_nxt      = ptr_r;
    rem_nxt      = rem_r;
    fill_nxt     = fill_r;
    last_len_nxt = last_len_r;
    idr_nxt      = idr_r;
    frag_nxt     = frag_r;
    drop_nxt     = drop_r;
    seqk_nxt     = seqk_r;
    prev_seq_nxt = prev_seq_r;
    seq_nxt      = seq_r;
    marker_nxt   = marker_r;
    ext_nxt      = ext_r;
    hi_nxt       = hi_r;
    pay0_nxt     = pay0_r;
    pay1_nxt     = pay1_r;
    nal0_nxt     = nal0_r;
    first_nxt    = first_r;
    sc_idx_nxt   = sc_idx_r;
    fin          = 1'b0;
    fin_rd       = 1'b0;
    fin_status   = PS_OK;
    fin_ready    = 1'b0;
    fin_len      = '0;
    fin_idr      = 1'b0;
    pkt_we       = 1'b0;
    pkt_waddr    = cnt_r[PA-1:0];
    pkt_raddr    = ptr_r[PA-1:0];
    unit_we      = 1'b0;
    unit_wdata   = pkt_q;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation) begin
            st_nxt = ST_RDATA;
          end else begin
            if (cnt_r < PKT_FULL) begin
              pkt_we  = 1'b1;
              cnt_nxt = cnt_r + PCW'(1);
            end else begin
              ovl_nxt = 1'b1;
            end
            if (in_last_byte) begin
              cnt_nxt = '0;
              ovl_nxt = 1'b0;
              if (ovl_r || cnt_r == PKT_FULL) begin
                fin        = 1'b1;
                fin_status = PS_TOO_LONG;
              end else begin
                len_nxt = LEN_W'(cnt_r) + LEN_W'(1);
                st_nxt  = ST_H0;
              end
            end
          end
        end
      end
      ST_RDATA: begin
        fin_rd = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_H0: begin
        pkt_raddr = '0;
        if (len_r < LEN_W'(RTP_HDR_LEN)) begin
          fin        = 1'b1;
          fin_status = PS_MALFORM;
          st_nxt     = ST_IDLE;
        end else begin
          st_nxt = ST_H1;
        end
      end
      ST_H1: begin
        pkt_raddr = PA'(1);
        if (pkt_q[7:6] != 2'(RTP_VERSION)) begin
          fin        = 1'b1;
          fin_status = PS_MALFORM;
          st_nxt     = ST_IDLE;
        end else begin
          hl_nxt  = POS_W'(RTP_HDR_LEN) + {{(POS_W-6){1'b0}}, pkt_q[3:0], 2'b00};
          ext_nxt = pkt_q[4];
          st_nxt  = ST_H2;
        end
      end
      ST_H2: begin
        marker_nxt = pkt_q[7];
        pkt_raddr  = PA'(2);
        st_nxt     = ST_H3;
      end
      ST_H3: begin
        seq_nxt[15:8] = pkt_q;
        pkt_raddr     = PA'(3);
        st_nxt        = ST_H4;
      end
      ST_H4: begin
        seq_nxt[7:0] = pkt_q;
        pkt_raddr    = hl_p2[PA-1:0];
        if (hl_r > len20 || (ext_r && (hl_r + POS_W'(SC_LEN)) > len20)) begin
          fin        = 1'b1;
          fin_status = PS_MALFORM;
          st_nxt     = ST_IDLE;
        end else begin
          st_nxt = ext_r ? ST_X1 : ST_SEQ;
        end
      end
      ST_X1: begin
        hi_nxt    = pkt_q;
        pkt_raddr = hl_p3[PA-1:0];
        st_nxt    = ST_X2;
      end
      ST_X2: begin
        if (nhl > len20) begin
          fin        = 1'b1;
          fin_status = PS_MALFORM;
          st_nxt     = ST_IDLE;
        end else begin
          hl_nxt = nhl;
          st_nxt = ST_SEQ;
        end
      end
      ST_SEQ: begin
        seqk_nxt     = 1'b1;
        prev_seq_nxt = seq_r;
        if (seqk_r && (seq_r - prev_seq_r) != 16'd1) begin
          drop_nxt = 1'b1;
          fill_nxt = '0;
          idr_nxt  = 1'b0;
          frag_nxt = 1'b0;
        end
        pkt_raddr = hl_r[PA-1:0];
        if (hl_r == len20) begin
          fin        = 1'b1;
          fin_status = PS_EMPTY;
          st_nxt     = ST_IDLE;
        end else begin
          st_nxt = ST_T0;
        end
      end
      ST_T0: begin
        pay0_nxt  = pkt_q;
        pkt_raddr = hl_p1[PA-1:0];
        st_nxt    = ST_T1;
      end
      ST_T1: begin
        // second payload byte is only meaningful when the payload has two bytes
        pay1_nxt = pkt_q;
        st_nxt   = ST_DISP;
        if (drop_r) begin
          if (ntype == NAL_FUA) begin
            if (!pl2) begin
              fin        = 1'b1;
              fin_status = PS_MALFORM;
              st_nxt     = ST_IDLE;
            end else if (pkt_q[7] && pkt_q[4:0] == NAL_IDR) begin
              drop_nxt = 1'b0;
            end else begin
              fin        = 1'b1;
              fin_status = PS_SKIP;
              st_nxt     = ST_IDLE;
            end
          end else if (ntype == NAL_STAPA) begin
            ptr_nxt = hl_p1;
            st_nxt  = ST_SN_LOOP;
          end else if (ntype == NAL_IDR) begin
            drop_nxt = 1'b0;
          end else begin
            fin        = 1'b1;
            fin_status = PS_SKIP;
            st_nxt     = ST_IDLE;
          end
        end
      end
      ST_DISP: begin
        if (ntype != 5'd0 && ntype <= NAL_SINGLE_MAX) begin
          job_nxt   = JOB_NAL;
          ptr_nxt   = hl_r;
          rem_nxt   = LEN_W'(len20 - hl_r);
          first_nxt = 1'b1;
          st_nxt    = fits(fill_r, LEN_W'(SC_LEN), cap) ? ST_SC : ST_FAIL;
        end else if (ntype == NAL_STAPA) begin
          ptr_nxt = hl_p1;
          st_nxt  = ST_SA_LOOP;
        end else if (ntype == NAL_FUA) begin
          ptr_nxt   = hl_p2;
          rem_nxt   = LEN_W'(len20 - hl_p2);
          first_nxt = 1'b0;
          if (!pl2) begin
            fin        = 1'b1;
            fin_status = PS_MALFORM;
            st_nxt     = ST_IDLE;
          end else if (pay1_r[7]) begin
            job_nxt  = JOB_FU_S;
            nal0_nxt = {pay0_r[7:5], pay1_r[4:0]};
            st_nxt   = fits(fill_r, LEN_W'(SC_LEN), cap) ? ST_SC : ST_FAIL;
          end else if (frag_r) begin
            job_nxt = JOB_FU_C;
            st_nxt  = ST_CHK;
          end else begin
            st_nxt = ST_FAIL;
          end
        end else begin
          st_nxt = ST_MARK;   // unsupported NAL type is ignored
        end
      end
      // IDR scan of an STAP-A while discarding
      ST_SN_LOOP: begin
        if (ptr_p2 > len20) begin
          fin        = 1'b1;
          fin_status = PS_SKIP;
          st_nxt     = ST_IDLE;
        end else begin
          st_nxt = ST_SN_H;
        end
      end
      ST_SN_H: begin
        hi_nxt    = pkt_q;
        pkt_raddr = ptr_p1[PA-1:0];
        st_nxt    = ST_SN_L;
      end
      ST_SN_L: begin
        pkt_raddr = ptr_p2[PA-1:0];
        ptr_nxt   = sz_end;
        if (sz_end > len20) begin
          fin        = 1'b1;
          fin_status = PS_SKIP;
          st_nxt     = ST_IDLE;
        end else begin
          st_nxt = (sz == 16'd0) ? ST_SN_LOOP : ST_SN_N;
        end
      end
      ST_SN_N: begin
        if (pkt_q[4:0] == NAL_IDR) begin
          drop_nxt = 1'b0;
          st_nxt   = ST_DISP;
        end else begin
          st_nxt = ST_SN_LOOP;
        end
      end
      // STAP-A entries
      ST_SA_LOOP: begin
        st_nxt = (ptr_p2 > len20) ? ST_MARK : ST_SA_H;
      end
      ST_SA_H: begin
        hi_nxt    = pkt_q;
        pkt_raddr = ptr_p1[PA-1:0];
        st_nxt    = ST_SA_L;
      end
      ST_SA_L: begin
        ptr_nxt   = ptr_p2;
        rem_nxt   = {1'b0, sz};
        job_nxt   = JOB_STAP;
        first_nxt = 1'b1;
        if (sz_end > len20) begin
          st_nxt = ST_FAIL;
        end else if (sz == 16'd0) begin
          st_nxt = ST_SA_LOOP;
        end else begin
          st_nxt = fits(fill_r, LEN_W'(SC_LEN), cap) ? ST_SC : ST_FAIL;
        end
      end
      // unit writes
      ST_SC: begin
        unit_we    = 1'b1;
        unit_wdata = (sc_idx_r == 2'd3) ? SC_LAST_BYTE : 8'd0;
        fill_nxt   = fill_r + LEN_W'(1);
        sc_idx_nxt = sc_idx_r + 2'd1;
        if (sc_idx_r == 2'd3) begin
          st_nxt = (job_r == JOB_FU_S) ? ST_HDR : ST_CHK;
        end
      end
      ST_HDR: begin
        if (fits(fill_r, LEN_W'(1), cap)) begin
          unit_we    = 1'b1;
          unit_wdata = nal0_r;
          fill_nxt   = fill_r + LEN_W'(1);
          st_nxt     = ST_CHK;
        end else begin
          st_nxt = ST_FAIL;
        end
      end
      ST_CHK: begin
        if (!fits(fill_r, rem_r, cap)) begin
          st_nxt = ST_FAIL;
        end else begin
          st_nxt = (rem_r == '0) ? ST_POST : ST_CP_RD;
        end
      end
      ST_CP_RD: begin
        st_nxt = ST_CP_WR;
      end
      ST_CP_WR: begin
        unit_we  = 1'b1;
        fill_nxt = fill_r + LEN_W'(1);
        ptr_nxt  = ptr_p1;
        rem_nxt  = rem_r - LEN_W'(1);
        if (first_r) begin
          nal0_nxt  = pkt_q;
          first_nxt = 1'b0;
        end
        st_nxt = (rem_r == LEN_W'(1)) ? ST_POST : ST_CP_RD;
      end
      ST_POST: begin
        st_nxt = ST_MARK;
        case (job_r)
          JOB_NAL: begin
            if (nal0_r[4:0] == NAL_IDR) idr_nxt = 1'b1;
          end
          JOB_STAP: begin
            if (nal0_r[4:0] == NAL_IDR) idr_nxt = 1'b1;
            st_nxt = ST_SA_LOOP;
          end
          JOB_FU_S: begin
            if (nal0_r[4:0] == NAL_IDR) idr_nxt = 1'b1;
            frag_nxt = !pay1_r[6];
          end
          JOB_FU_C: begin
            if (pay1_r[6]) frag_nxt = 1'b0;
          end
          default: begin
            st_nxt = ST_MARK;
          end
        endcase
      end
      ST_MARK: begin
        fin    = 1'b1;
        st_nxt = ST_IDLE;
        if (marker_r) begin
          if (fill_r != '0) begin
            fin_ready    = 1'b1;
            fin_len      = fill_r;
            fin_idr      = idr_r;
            last_len_nxt = fill_r;
          end
          fill_nxt = '0;
          idr_nxt  = 1'b0;
          frag_nxt = 1'b0;
        end
      end
      ST_FAIL: begin
        fin        = 1'b1;
        fin_status = PS_OVERFLOW;
        drop_nxt   = 1'b1;
        fill_nxt   = '0;
        idr_nxt    = 1'b0;
        frag_nxt   = 1'b0;
        st_nxt     = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      job_r       <= JOB_NAL;
      cnt_r       <= '0;
      ovl_r       <= 1'b0;
      fill_r      <= '0;
      last_len_r  <= '0;
      idr_r       <= 1'b0;
      frag_r      <= 1'b0;
      drop_r      <= 1'b0;
      seqk_r      <= 1'b0;
      prev_seq_r  <= '0;
      first_r     <= 1'b0;
      sc_idx_r    <= '0;
      au_limit_r  <= LEN_W'(65536);
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      job_r      <= job_nxt;
      cnt_r      <= cnt_nxt;
      ovl_r      <= ovl_nxt;
      fill_r     <= fill_nxt;
      last_len_r <= last_len_nxt;
      idr_r      <= idr_nxt;
      frag_r     <= frag_nxt;
      drop_r     <= drop_nxt;
      seqk_r     <= seqk_nxt;
      prev_seq_r <= prev_seq_nxt;
      first_r    <= first_nxt;
      sc_idx_r   <= sc_idx_nxt;
      if (cfg_valid) begin
        au_limit_r <= cfg_au_limit;
      end
      if (fin || fin_rd) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers of the current packet and the result payload
  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    hl_r     <= hl_nxt;
    ptr_r    <= ptr_nxt;
    rem_r    <= rem_nxt;
    seq_r    <= seq_nxt;
    marker_r <= marker_nxt;
    ext_r    <= ext_nxt;
    hi_r     <= hi_nxt;
    pay0_r   <= pay0_nxt;
    pay1_r   <= pay1_nxt;
    nal0_r   <= nal0_nxt;
    if (fin) begin
      out_kind_r   <= 1'b0;
      out_status_r <= fin_status;
      out_uready_r <= fin_ready;
      out_len_r    <= fin_len;
      out_idr_r    <= fin_idr;
      out_disc_r   <= drop_nxt;
      out_data_r   <= 8'd0;
    end else if (fin_rd) begin
      out_kind_r   <= 1'b1;
      out_status_r <= PS_OK;
      out_uready_r <= 1'b0;
      out_len_r    <= last_len_r;
      out_idr_r    <= 1'b0;
      out_disc_r   <= drop_r;
      out_data_r   <= unit_rdata;
    end
  end

  // packet store: one write port for arriving bytes, one read port for parsing
  always_ff @(posedge clk) begin
    if (pkt_we) begin
      pkt_mem[pkt_waddr] <= in_data_byte;
    end
    pkt_q <= pkt_mem[pkt_raddr];
  end

  rhd_unit_store #(
    .UNIT_DEPTH (UNIT_DEPTH)
  ) u_unit_store (
    .clk     (clk),
    .wr_en   (unit_we),
    .wr_addr (fill_ext[UA-1:0]),
    .wr_data (unit_wdata),
    .rd_addr (raddr_ext[UA-1:0]),
    .rd_hit  (rd_hit),
    .rd_data (unit_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_packet_status  = out_status_r;
  assign out_unit_ready     = out_uready_r;
  assign out_unit_length    = out_len_r;
  assign out_unit_has_idr   = out_idr_r;
  assign out_discarding_now = out_disc_r;
  assign out_read_data      = out_data_r;

  // ---------------------------------------------------------------- checks
  // no result may be pending while a transaction is still being worked on
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending during processing");

  // every unit write lands inside the capacity in use
  a_write_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    unit_we |-> (fill_r < cap))
    else $error("unit store write beyond capacity");

  // a reported unit is never empty
  a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r && out_uready_r) |-> (out_len_r != '0))
    else $error("empty unit reported ready");

  // a finished transaction always shows up on the result channel
  a_fin_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin || fin_rd) |=> out_valid_r)
    else $error("finished transaction lost");

endmodule
